/* rtl/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants for the priority ready queue
// Field widths, request and status codes, and the words passed between the
// top level and the sequencer.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int TASK_W        = 8;
	localparam int PRIO_W        = 6;
	localparam int REQ_W         = 2;
	localparam int STATUS_W      = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_REPRIO = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_IDLE      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DUP       = 3'd4
	} status_t;

	// one queue entry as stored in the slot memory
	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	typedef struct packed {
		req_t              kind;
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] prio;
	} req_word_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] prio;
		status_t           status;
	} rsp_word_t;

endpackage

/* rtl/priority_ready_queue_top.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_top: priority-sorted ready queue of task ids
// Each request runs a scan pass over the queued entries; a successful insert
//   or reprioritize then runs a place pass as well.
// Throughput: one request at a time; in_ready returns as the result word
//   enters the output register.
// Reset: arst_n clears the queue to empty and the idle id to zero; the slot
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
module priority_ready_queue_top #(
	parameter int QUEUE_DEPTH = prq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prq_pkg::REQ_W-1:0]     req_type,
	input  logic [prq_pkg::TASK_W-1:0]    task_id,
	input  logic [prq_pkg::PRIO_W-1:0]    task_priority,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prq_pkg::TASK_W-1:0]    out_task_id,
	output logic [prq_pkg::PRIO_W-1:0]    out_priority,
	output logic [prq_pkg::STATUS_W-1:0]  status,
	// idle task id register
	input  logic                          cfg_we,
	input  logic [prq_pkg::TASK_W-1:0]    cfg_wdata
);

	logic [prq_pkg::TASK_W-1:0] idle_id_q;
	prq_pkg::req_word_t         req_word;
	prq_pkg::rsp_word_t         rsp_word;
	prq_pkg::rsp_word_t         out_q;
	logic                       out_valid_q;
	logic                       rsp_valid;
	logic                       rsp_ready;

	// Idle id register: the user must write it only while the queue is quiet; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_id_q <= '0;
		end else if (cfg_we) begin
			idle_id_q <= cfg_wdata;
		end
	end

	// Pack the request word for the sequencer.
	assign req_word.kind    = prq_pkg::req_t'(req_type);
	assign req_word.task_id = task_id;
	assign req_word.prio    = task_priority;

	// The sequencer does all queue work: a scan pass over the occupied slots,
	// then for insert and reprioritize a place pass that ripples entries back.
	prq_seq #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req_word),
		.req_ready (in_ready),
		.idle_id   (idle_id_q),
		.rsp_valid (rsp_valid),
		.rsp       (rsp_word),
		.rsp_ready (rsp_ready)
	);

	// Output register: hold the result word until taken, so the sequencer
	// can go back to idle and accept the next request meanwhile.
	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= rsp_word;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_task_id  = out_q.task_id;
	assign out_priority = out_q.prio;
	assign status       = out_q.status;

	// A request keeps the sequencer busy: in_ready is low in the cycle after it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer ready right after accepting a request");

	// Only a successful pop reports a priority.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != prq_pkg::ST_OK) |-> (out_priority == '0))
		else $error("nonzero priority on a failed request");

	// Status codes stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == prq_pkg::ST_OK || status == prq_pkg::ST_FULL ||
		               status == prq_pkg::ST_IDLE || status == prq_pkg::ST_NOT_FOUND ||
		               status == prq_pkg::ST_DUP))
		else $error("undefined status code");

endmodule

/* rtl/prq_ram.sv */
// ----------------------------------------------------------------------------
// prq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prq_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/prq_seq.sv */
// ----------------------------------------------------------------------------
// prq_seq: queue sequencer
// Walks the slot memory one entry per cycle through a shared compare unit:
// a scan pass (locate, with forward shift on delete) and a place pass
// (ripple insert behind entries of equal or higher priority).
// ----------------------------------------------------------------------------
module prq_seq #(
	parameter int QUEUE_DEPTH = prq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  prq_pkg::req_word_t            req,
	output logic                          req_ready,
	input  logic [prq_pkg::TASK_W-1:0]    idle_id,
	output logic                          rsp_valid,
	output prq_pkg::rsp_word_t            rsp,
	input  logic                          rsp_ready
);

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W = $bits(prq_pkg::slot_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_DONE
	} state_t;

	state_t             state_q;
	prq_pkg::req_word_t req_q;
	prq_pkg::rsp_word_t rsp_q;
	prq_pkg::slot_t     hold_q;
	logic [CNT_W-1:0]   occ_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   rd_end_q;
	logic               found_q;
	logic               ins_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               issue;
	logic               drained;
	logic [IDX_W-1:0]   rd_addr;
	logic [SLOT_W-1:0]  ram_rdata;
	prq_pkg::slot_t     rd_d;
	logic               scan_hit;
	logic               slot_live;
	logic               place_here;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	prq_pkg::slot_t     ram_wdata;

	assign issue   = (state_q == S_SCAN || state_q == S_PLACE) && (rd_idx_q < rd_end_q);
	assign drained = !issue && !vld_s1;
	assign rd_addr = rd_idx_q[IDX_W-1:0];
	assign rd_d    = prq_pkg::slot_t'(ram_rdata);

	// shared compare unit
	assign scan_hit   = (req_q.kind == prq_pkg::REQ_POP) ? (idx_s1 == '0)
	                                                     : (rd_d.task_id == req_q.task_id);
	assign slot_live  = CNT_W'(idx_s1) < occ_q;
	assign place_here = !ins_q && (!slot_live || (rd_d.prio < hold_q.prio));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = hold_q;
		if (state_q == S_SCAN) begin
			// shift entries behind a deleted one forward by one slot
			if (vld_s1 && found_q && req_q.kind != prq_pkg::REQ_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = idx_s1 - IDX_W'(1);
				ram_wdata = rd_d;
			end
		end else if (state_q == S_PLACE) begin
			if (vld_s1 && (ins_q || place_here)) begin
				ram_we = 1'b1;
			end
		end
	end

	prq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (SLOT_W'(ram_wdata)),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= rd_addr;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q         <= req;
						rsp_q.task_id <= req.task_id;
						rsp_q.prio    <= '0;
						rsp_q.status  <= prq_pkg::ST_OK;
						rd_idx_q      <= '0;
						rd_end_q      <= occ_q;
						found_q       <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (vld_s1 && !found_q && scan_hit) begin
						found_q <= 1'b1;
						if (req_q.kind == prq_pkg::REQ_POP) begin
							rsp_q.task_id <= rd_d.task_id;
							rsp_q.prio    <= rd_d.prio;
						end
					end
					if (drained) begin
						state_q <= S_DONE;
						case (req_q.kind)
							prq_pkg::REQ_INSERT: begin
								if (found_q) begin
									rsp_q.status <= prq_pkg::ST_DUP;
								end else if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
									rsp_q.status <= prq_pkg::ST_FULL;
								end else begin
									rd_idx_q       <= '0;
									rd_end_q       <= occ_q + CNT_W'(1);
									hold_q.task_id <= req_q.task_id;
									hold_q.prio    <= req_q.prio;
									ins_q          <= 1'b0;
									state_q        <= S_PLACE;
								end
							end
							prq_pkg::REQ_POP: begin
								if (occ_q == '0) begin
									rsp_q.task_id <= idle_id;
									rsp_q.status  <= prq_pkg::ST_IDLE;
								end else begin
									occ_q <= occ_q - CNT_W'(1);
								end
							end
							prq_pkg::REQ_REMOVE: begin
								if (found_q) begin
									occ_q <= occ_q - CNT_W'(1);
								end else begin
									rsp_q.status <= prq_pkg::ST_NOT_FOUND;
								end
							end
							prq_pkg::REQ_REPRIO: begin
								if (found_q) begin
									// reinsert into the shortened queue
									occ_q          <= occ_q - CNT_W'(1);
									rd_idx_q       <= '0;
									rd_end_q       <= occ_q;
									hold_q.task_id <= req_q.task_id;
									hold_q.prio    <= req_q.prio;
									ins_q          <= 1'b0;
									state_q        <= S_PLACE;
								end else begin
									rsp_q.status <= prq_pkg::ST_NOT_FOUND;
								end
							end
							default: begin
								rsp_q.status <= prq_pkg::ST_NOT_FOUND;
							end
						endcase
					end
				end
				S_PLACE: begin
					// carry the displaced entry one slot back each cycle
					if (vld_s1 && (ins_q || place_here)) begin
						hold_q <= rd_d;
						ins_q  <= 1'b1;
					end
					if (drained) begin
						occ_q   <= occ_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign rsp       = rsp_q;

endmodule
